// File: sv/rsnp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsnp_pkg: shared definitions for the ray to bone segment picker
// Register indexes, fixed-point limits and saturating helper functions.
// ----------------------------------------------------------------------------
package rsnp_pkg;

  // Largest parent index plus one that can still win a pick.
  localparam int MAX_BONES = 256;

  // Small-value threshold, Q32.32.
  localparam logic signed [63:0] SMALL_THRESHOLD = 64'sd4295;

  localparam logic signed [63:0] Q64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [31:0] Q32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q32_MIN = 32'sh8000_0000;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [2:0] REG_DIR_X     = 3'd3;
  localparam logic [2:0] REG_DIR_Y     = 3'd4;
  localparam logic [2:0] REG_DIR_Z     = 3'd5;
  localparam logic [2:0] REG_RADIUS_SQ = 3'd6;

  // Saturate a wide signed value to the Q16.16 range.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = Q32_MAX;
    end else if (v < -66'sd2147483648) begin
      r = Q32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturating signed 64-bit add.
  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [63:0] r;
    s = 65'(a) + 65'(b);
    if (s > 65'(Q64_MAX)) begin
      r = Q64_MAX;
    end else if (s < 65'(Q64_MIN)) begin
      r = Q64_MIN;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

endpackage

// File: sv/rsnp_frac_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsnp_frac_div: clamped fractional divider
// Returns num/den clamped to 0..1 in Q1.16, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsnp_frac_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               done,
  output logic [16:0]        quot
);
  import rsnp_pkg::*;

  logic        busy;
  logic [3:0]  cnt;
  logic [62:0] rem;
  logic [62:0] dvs;
  logic [15:0] q;
  logic [63:0] rem_sh;
  logic        take;

  // One restoring step: shift the remainder and try to subtract.
  assign rem_sh = {rem, 1'b0};
  assign take   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // Clamped cases finish at once.
        if (num <= 64'sd0) begin
          quot <= 17'd0;
          done <= 1'b1;
        end else if (num >= den) begin
          quot <= 17'h10000;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= '0;
          rem  <= num[62:0];
          dvs  <= den[62:0];
          q    <= '0;
        end
      end else if (busy) begin
        if (take) begin
          rem <= 63'(rem_sh - {1'b0, dvs});
        end else begin
          rem <= rem_sh[62:0];
        end
        q   <= {q[14:0], take};
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= {1'b0, q[14:0], take};
        end
      end
    end
  end

endmodule

// File: sv/ray_segment_nearest_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_segment_nearest_pick: nearest bone segment along a picking ray
// Streams bone segments, keeps the nearest one within the pick radius and
// reports its parent index on the last segment of a pick.
// ----------------------------------------------------------------------------
// One request is one bone segment. Between acceptance and the next ready, a
// valid segment runs 27 products through one shared 33 x 33 bit multiplier,
// each through a multiply state and then an accumulate or saturate state,
// after the idle state that accepts it and before the finish state, and it
// waits on the serial quotient unit when the general or near-parallel case
// needs a division (the unit skips its bit steps when the quotient clamps). A
// skipped segment (no parent, or a degenerate direction found after three
// products) goes straight on to the finish state. The input side is not ready
// while a segment is being worked on. The result of a pick sits in an output
// register; a new pick ending before it is taken waits for it.
module ray_segment_nearest_pick (
  input  logic               clk,
  input  logic               rst,
  // Segment requests
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] start_z,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [31:0] end_z,
  input  logic [7:0]         parent_id,
  input  logic               has_parent,
  input  logic               last_segment,
  // Pick results
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic signed [8:0]  best_bone,
  // Configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rsnp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    G_DLEN,
    G_SEG,
    G_PAIR,
    G_RAYT,
    G_PT
  } group_t;

  // Configuration registers.
  logic signed [31:0] origin [3];
  logic signed [17:0] dir [3];
  logic [30:0]        radius_sq;

  // Sequencer state.
  state_t     state;
  group_t     grp;
  logic [1:0] ax;
  logic [1:0] kind;

  // Per-segment working registers.
  logic signed [31:0] seg_s [3];
  logic signed [31:0] seg_v [3];
  logic signed [31:0] dif [3];
  logic [7:0]         pid;
  logic               last_q;
  logic signed [37:0] dlen;
  logic signed [63:0] len2;
  logic signed [63:0] sdd;
  logic signed [50:0] rsd_raw;
  logic signed [50:0] rdd_raw;
  logic signed [63:0] rsd2;
  logic [16:0]        t;
  logic signed [31:0] ray_t;
  logic signed [31:0] preg;
  logic signed [31:0] greg;
  logic signed [63:0] dist2;
  logic signed [65:0] prod;

  // Pick state.
  logic signed [31:0] best_ray_t;
  logic [8:0]         best_index;
  logic               any_hit;

  // Shared multiplier operands.
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;

  // Derived values.
  logic signed [31:0] rsd;
  logic signed [31:0] rdd;
  logic signed [31:0] prod_q;
  logic signed [37:0] dlen_sum;
  logic signed [31:0] ray_sum;
  logic signed [31:0] q_pt;
  logic signed [31:0] p_pt;
  logic signed [63:0] dist_sum;
  logic signed [63:0] gen_den;
  logic               gen_case;
  logic signed [63:0] div_num;
  logic signed [63:0] div_den;
  logic               div_start;
  logic               div_done;
  logic [16:0]        div_quot;
  logic               cfg_wr;
  logic               accept;
  logic               eval_ok;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign eval_ok  = has_parent && (int'(parent_id) < MAX_BONES);

  // Configuration read back.
  always_comb begin
    unique case (paddr[4:2])
      REG_ORIGIN_X:  prdata = origin[0];
      REG_ORIGIN_Y:  prdata = origin[1];
      REG_ORIGIN_Z:  prdata = origin[2];
      REG_DIR_X:     prdata = 32'(dir[0]);
      REG_DIR_Y:     prdata = 32'(dir[1]);
      REG_DIR_Z:     prdata = 32'(dir[2]);
      REG_RADIUS_SQ: prdata = {1'b0, radius_sq};
      default:       prdata = '0;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0] <= '0;
      origin[1] <= '0;
      origin[2] <= '0;
      dir[0]    <= 18'sd65536;
      dir[1]    <= '0;
      dir[2]    <= '0;
      radius_sq <= 31'd419;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_ORIGIN_X:  origin[0] <= pwdata;
        REG_ORIGIN_Y:  origin[1] <= pwdata;
        REG_ORIGIN_Z:  origin[2] <= pwdata;
        REG_DIR_X:     dir[0]    <= pwdata[17:0];
        REG_DIR_Y:     dir[1]    <= pwdata[17:0];
        REG_DIR_Z:     dir[2]    <= pwdata[17:0];
        REG_RADIUS_SQ: radius_sq <= pwdata[30:0];
        default:       ;
      endcase
    end
  end

  // Dot products along the ray, back in Q16.16.
  assign rsd = sat32(66'(rsd_raw >>> 16));
  assign rdd = sat32(66'(rdd_raw >>> 16));

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (grp)
      G_DLEN: begin
        mul_a = 33'(dir[ax]);
        mul_b = 33'(dir[ax]);
      end
      G_SEG: begin
        case (kind)
          2'd0: begin
            mul_a = 33'(seg_v[ax]);
            mul_b = 33'(seg_v[ax]);
          end
          2'd1: begin
            mul_a = 33'(seg_v[ax]);
            mul_b = 33'(dif[ax]);
          end
          2'd2: begin
            mul_a = 33'(dir[ax]);
            mul_b = 33'(seg_v[ax]);
          end
          default: begin
            mul_a = 33'(dir[ax]);
            mul_b = 33'(dif[ax]);
          end
        endcase
      end
      G_PAIR: begin
        mul_a = 33'(rsd);
        mul_b = (kind == 2'd0) ? 33'(rsd) : 33'(rdd);
      end
      G_RAYT: begin
        mul_a = $signed({16'd0, t});
        mul_b = 33'(rsd);
      end
      default: begin
        case (kind)
          2'd0: begin
            mul_a = 33'(dir[ax]);
            mul_b = 33'(ray_t);
          end
          2'd1: begin
            mul_a = 33'(seg_v[ax]);
            mul_b = $signed({16'd0, t});
          end
          default: begin
            mul_a = 33'(greg);
            mul_b = 33'(greg);
          end
        endcase
      end
    endcase
  end

  // Post-multiply arithmetic used in the accumulate cycle. The division is
  // started in the cycle that holds rsd * rdd in the product register.
  always_comb begin
    logic signed [31:0] r;
    prod_q   = sat32(prod >>> 16);
    dlen_sum = dlen + 38'(prod);
    r        = sat32(66'(prod_q) - 66'(rdd));
    ray_sum  = (r < 32'sd0) ? 32'sd0 : r;
    p_pt     = sat32(66'(origin[ax]) + 66'(prod_q));
    q_pt     = sat32(66'(seg_s[ax]) + 66'(prod_q));
    dist_sum = sadd64(dist2, prod[63:0]);
    gen_den  = len2 - rsd2;
    gen_case = (len2 > rsd2) && (gen_den > SMALL_THRESHOLD);
    if (gen_case) begin
      div_num = sadd64(sdd, -prod[63:0]);
      div_den = gen_den;
    end else begin
      div_num = (sdd == Q64_MIN) ? Q64_MAX : -sdd;
      div_den = len2;
    end
  end

  assign div_start = (state == ST_ACC) && (grp == G_PAIR) && (kind == 2'd1)
                     && (len2 > SMALL_THRESHOLD);

  rsnp_frac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer, working registers, pick state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      grp        <= G_DLEN;
      ax         <= '0;
      kind       <= '0;
      out_valid  <= 1'b0;
      best_ray_t <= Q32_MAX;
      best_index <= 9'h1FF;
      any_hit    <= 1'b0;
    end else begin
      // A taken result frees the register unless a new one is loaded now.
      if (out_valid && out_ready && !(state == ST_FINISH && last_q)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            seg_s[0] <= start_x;
            seg_s[1] <= start_y;
            seg_s[2] <= start_z;
            seg_v[0] <= sat32(66'(end_x) - 66'(start_x));
            seg_v[1] <= sat32(66'(end_y) - 66'(start_y));
            seg_v[2] <= sat32(66'(end_z) - 66'(start_z));
            dif[0]   <= sat32(66'(origin[0]) - 66'(start_x));
            dif[1]   <= sat32(66'(origin[1]) - 66'(start_y));
            dif[2]   <= sat32(66'(origin[2]) - 66'(start_z));
            pid      <= parent_id;
            last_q   <= last_segment;
            dlen     <= '0;
            len2     <= '0;
            sdd      <= '0;
            rsd_raw  <= '0;
            rdd_raw  <= '0;
            dist2    <= '0;
            grp      <= G_DLEN;
            ax       <= '0;
            kind     <= '0;
            state    <= eval_ok ? ST_MUL : ST_FINISH;
          end
        end
        ST_MUL: begin
          prod  <= mul_a * mul_b;
          state <= ST_ACC;
        end
        ST_ACC: begin
          state <= ST_MUL;
          case (grp)
            G_DLEN: begin
              dlen <= dlen_sum;
              ax   <= ax + 2'd1;
              if (ax == 2'd2) begin
                ax  <= '0;
                grp <= G_SEG;
                if (64'(dlen_sum) <= SMALL_THRESHOLD) begin
                  state <= ST_FINISH;
                end
              end
            end
            G_SEG: begin
              case (kind)
                2'd0:    len2    <= sadd64(len2, prod[63:0]);
                2'd1:    sdd     <= sadd64(sdd, prod[63:0]);
                2'd2:    rsd_raw <= rsd_raw + 51'(prod);
                default: rdd_raw <= rdd_raw + 51'(prod);
              endcase
              kind <= kind + 2'd1;
              if (kind == 2'd3) begin
                ax <= ax + 2'd1;
                if (ax == 2'd2) begin
                  ax  <= '0;
                  grp <= G_PAIR;
                end
              end
            end
            G_PAIR: begin
              if (kind == 2'd0) begin
                rsd2 <= prod[63:0];
                kind <= 2'd1;
              end else begin
                kind <= '0;
                grp  <= G_RAYT;
                // A degenerate segment uses its start point.
                if (len2 <= SMALL_THRESHOLD) begin
                  t <= '0;
                end else begin
                  state <= ST_DIV;
                end
              end
            end
            G_RAYT: begin
              ray_t <= ray_sum;
              grp   <= G_PT;
              ax    <= '0;
              kind  <= '0;
            end
            default: begin
              case (kind)
                2'd0: begin
                  preg <= p_pt;
                  kind <= 2'd1;
                end
                2'd1: begin
                  greg <= sat32(66'(preg) - 66'(q_pt));
                  kind <= 2'd2;
                end
                default: begin
                  dist2 <= dist_sum;
                  kind  <= '0;
                  ax    <= ax + 2'd1;
                  if (ax == 2'd2) begin
                    state <= ST_FINISH;
                    if ((dist_sum <= $signed({17'd0, radius_sq, 16'd0}))
                        && (ray_t < best_ray_t)) begin
                      best_ray_t <= ray_t;
                      best_index <= {1'b0, pid};
                      any_hit    <= 1'b1;
                    end
                  end
                end
              endcase
            end
          endcase
        end
        ST_DIV: begin
          if (div_done) begin
            t     <= div_quot;
            state <= ST_MUL;
          end
        end
        ST_FINISH: begin
          // Close the pick once the result register is free.
          if (!last_q) begin
            state <= ST_IDLE;
          end else if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            hit        <= any_hit;
            best_bone  <= any_hit ? best_index : 9'h1FF;
            best_ray_t <= Q32_MAX;
            best_index <= 9'h1FF;
            any_hit    <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sv/rsnp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsnp_checker: port-level checks for the segment picker
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module rsnp_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              hit,
  input logic signed [8:0] best_bone
);

  // A held result stays until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // A miss always reports no bone.
  a_miss_bone: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> best_bone == 9'h1FF)
    else $error("miss reported with a bone index");

  // A hit always reports a real bone index.
  a_hit_bone: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !best_bone[8])
    else $error("hit reported without a bone index");

  // An accepted segment blocks a back-to-back acceptance of the next request.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted back to back");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind ray_segment_nearest_pick rsnp_checker u_rsnp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .hit       (hit),
  .best_bone (best_bone)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ray to bone segment picker
// Streams bone segments through the request channel under random gaps and
// output stalls, predicts each pick result in fixed point, and compares the
// hit flag and winning bone against what the block returns.
// ----------------------------------------------------------------------------
module testbench;
  import rsnp_pkg::*;

  typedef struct {
    logic signed [31:0] sx, sy, sz, ex, ey, ez;
    logic [7:0]         pid;
    logic               has_par;
    logic               last;
  } segment_t;

  typedef struct {
    logic               hit;
    logic signed [8:0]  bone;
  } pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] start_x = '0, start_y = '0, start_z = '0;
  logic signed [31:0] end_x = '0, end_y = '0, end_z = '0;
  logic [7:0]         parent_id = '0;
  logic               has_parent = 1'b0;
  logic               last_segment = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               hit;
  logic signed [8:0]  best_bone;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  ray_segment_nearest_pick DUT (.*);

  // Predictor copy of the configuration and of the running pick.
  logic signed [63:0] cfg_org [3];
  logic signed [63:0] cfg_dir [3];
  logic signed [63:0] cfg_rad;
  logic signed [63:0] near_t;
  logic signed [63:0] near_bone;
  logic               near_any;

  segment_t pending_segments[$];
  pick_t    expected_picks[$];
  int       mismatch_count = 0;
  bit       stimulus_done = 1'b0;
  bit       hold_off = 1'b0;
  int       hold_cycles = 0;
  int       send_gap = 0;
  int       take_gap = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Floor shift of a Q32.32 product down to Q16.16.
  function automatic logic signed [63:0] floor16(input logic signed [63:0] p);
    return p >>> 16;
  endfunction

  function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    return clip32(floor16(a * b));
  endfunction

  // Clamped fraction num/den in Q16.16, computed bit by bit.
  function automatic logic signed [63:0] unit_ratio(input logic signed [63:0] num,
                                                    input logic signed [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    if (num <= 0) return 0;
    if (num >= den) return 65536;
    r = 65'(num);
    q = 0;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= 65'(den)) begin
        r = r - 65'(den);
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Fold one segment into the running pick.
  task automatic fold_segment(input segment_t sg);
    logic signed [63:0] s [3];
    logic signed [63:0] e [3];
    logic signed [63:0] sv [3];
    logic signed [63:0] dv [3];
    logic signed [63:0] len2, sdd, rsd, rdd, dlen, t, ray_t, dist2, rsd2, p, q, g;
    s[0] = sg.sx; s[1] = sg.sy; s[2] = sg.sz;
    e[0] = sg.ex; e[1] = sg.ey; e[2] = sg.ez;
    len2 = 0; sdd = 0; rsd = 0; rdd = 0; dlen = 0; dist2 = 0;
    for (int i = 0; i < 3; i++) dlen += cfg_dir[i] * cfg_dir[i];
    if (dlen <= SMALL_THRESHOLD) return;
    for (int i = 0; i < 3; i++) begin
      sv[i] = clip32(e[i] - s[i]);
      dv[i] = clip32(cfg_org[i] - s[i]);
      len2 = add_sat(len2, sv[i] * sv[i]);
      sdd = add_sat(sdd, sv[i] * dv[i]);
      rsd += cfg_dir[i] * sv[i];
      rdd += cfg_dir[i] * dv[i];
    end
    rsd = clip32(floor16(rsd));
    rdd = clip32(floor16(rdd));
    if (len2 <= SMALL_THRESHOLD) begin
      t = 0;
    end else begin
      rsd2 = rsd * rsd;
      if (len2 > rsd2 && len2 - rsd2 > SMALL_THRESHOLD) begin
        t = unit_ratio(add_sat(sdd, -(rsd * rdd)), len2 - rsd2);
      end else begin
        t = unit_ratio((sdd == Q64_MIN) ? Q64_MAX : -sdd, len2);
      end
    end
    ray_t = clip32(qmul(t, rsd) - rdd);
    if (ray_t < 0) ray_t = 0;
    for (int i = 0; i < 3; i++) begin
      p = clip32(cfg_org[i] + qmul(cfg_dir[i], ray_t));
      q = clip32(s[i] + qmul(sv[i], t));
      g = clip32(p - q);
      dist2 = add_sat(dist2, g * g);
    end
    if (dist2 <= (cfg_rad <<< 16) && ray_t < near_t) begin
      near_t = ray_t;
      near_bone = sg.pid;
      near_any = 1'b1;
    end
  endtask

  task automatic clear_pick();
    near_t = 64'sd2147483647;
    near_bone = -1;
    near_any = 1'b0;
  endtask

  task automatic predict_segment(input segment_t sg);
    pick_t pk;
    if (sg.has_par && sg.pid < MAX_BONES) fold_segment(sg);
    if (sg.last) begin
      pk.hit = near_any;
      pk.bone = near_any ? near_bone[8:0] : 9'h1FF;
      expected_picks = {expected_picks, pk};
      clear_pick();
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Register write over the configuration port, mirrored into the predictor.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ORIGIN_X:  cfg_org[0] = $signed(val);
      REG_ORIGIN_Y:  cfg_org[1] = $signed(val);
      REG_ORIGIN_Z:  cfg_org[2] = $signed(val);
      REG_DIR_X:     cfg_dir[0] = $signed(val[17:0]);
      REG_DIR_Y:     cfg_dir[1] = $signed(val[17:0]);
      REG_DIR_Z:     cfg_dir[2] = $signed(val[17:0]);
      REG_RADIUS_SQ: cfg_rad = {33'd0, val[30:0]};
      default: ;
    endcase
  endtask

  task automatic set_ray(input logic [31:0] ox, oy, oz, dx, dy, dz, rad);
    write_reg(REG_ORIGIN_X, ox); write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz); write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);    write_reg(REG_DIR_Z, dz);
    write_reg(REG_RADIUS_SQ, rad);
  endtask

  // Wait for the block to drain before touching the registers again.
  task automatic wait_idle();
    while (pending_segments.size() != 0 || in_valid || expected_picks.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(input int scale);
    case (scale)
      0: return $signed($urandom_range(0, 8 * 65536)) - 32'sd262144;
      1: return $signed($urandom_range(0, 256 * 65536)) - 32'sd8388608;
      default: return $signed($urandom);
    endcase
  endfunction

  // Segment passing near the configured ray, or a random one.
  function automatic segment_t rand_segment(input bit last);
    segment_t sg;
    int scale;
    logic signed [31:0] ax;
    scale = ($urandom_range(0, 9) < 7) ? 0 : ($urandom_range(0, 1) ? 1 : 2);
    sg.sx = rand_coord(scale); sg.sy = rand_coord(scale); sg.sz = rand_coord(scale);
    sg.ex = rand_coord(scale); sg.ey = rand_coord(scale); sg.ez = rand_coord(scale);
    if ($urandom_range(0, 3) != 0 && scale == 0) begin
      // Straddle the ray axis through the origin so the pick can hit.
      ax = $signed($urandom_range(0, 20 * 65536));
      sg.sx = cfg_org[0][31:0] + ax + $signed($urandom_range(0, 16384)) - 8192;
      sg.ex = sg.sx + $signed($urandom_range(0, 8192)) - 4096;
      sg.sy = cfg_org[1][31:0] - $signed($urandom_range(0, 65536));
      sg.ey = cfg_org[1][31:0] + $signed($urandom_range(0, 65536));
      sg.sz = cfg_org[2][31:0] + $signed($urandom_range(0, 16384)) - 8192;
      sg.ez = cfg_org[2][31:0] + $signed($urandom_range(0, 16384)) - 8192;
      if ($urandom_range(0, 5) == 0) begin
        sg.ex = sg.sx; sg.ey = sg.sy; sg.ez = sg.sz;
      end
    end
    sg.pid = $urandom_range(0, 255);
    sg.has_par = ($urandom_range(0, 7) != 0);
    sg.last = last;
    return sg;
  endfunction

  function automatic segment_t mk(input logic signed [31:0] sx, sy, sz, ex, ey, ez,
                                  input logic [7:0] pid, input bit hp, input bit last);
    segment_t sg;
    sg.sx = sx; sg.sy = sy; sg.sz = sz; sg.ex = ex; sg.ey = ey; sg.ez = ez;
    sg.pid = pid; sg.has_par = hp; sg.last = last;
    return sg;
  endfunction

  // Predict at queue time; order matches acceptance order.
  task automatic queue_segment(input segment_t sg);
    predict_segment(sg);
    pending_segments = {pending_segments, sg};
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0;
      end else if (!in_valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_segments.size() != 0) begin
          segment_t sg;
          sg = pending_segments.pop_front();
          start_x <= sg.sx; start_y <= sg.sy; start_z <= sg.sz;
          end_x <= sg.ex; end_y <= sg.ey; end_z <= sg.ez;
          parent_id <= sg.pid; has_parent <= sg.has_par; last_segment <= sg.last;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Result monitor with random stalls and one long hold-off.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_picks.size() == 0) begin
          report_mismatch("unexpected pick", hit, -1);
        end else begin
          pick_t pk;
          pk = expected_picks.pop_front();
          if (hit !== pk.hit) report_mismatch("hit", hit, pk.hit);
          if (best_bone !== pk.bone) report_mismatch("best_bone", best_bone, pk.bone);
        end
      end
      if (hold_off) begin
        out_ready <= 1'b0;
        if (hold_cycles >= 3000) begin
          hold_off <= 1'b0;
        end
        hold_cycles <= hold_cycles + 1;
      end else if (take_gap > 0) begin
        out_ready <= 1'b0;
        take_gap <= take_gap - 1;
      end else if (out_valid && out_ready) begin
        out_ready <= 1'b0;
        take_gap <= $urandom_range(0, 2) == 0 ? $urandom_range(0, 12) : 0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int n, len, waited;
    cfg_org[0] = 0; cfg_org[1] = 0; cfg_org[2] = 0;
    cfg_dir[0] = 65536; cfg_dir[1] = 0; cfg_dir[2] = 0;
    cfg_rad = 419;
    clear_pick();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset ray along +x with the default radius.
    queue_segment(mk(32'sh0005_0000, -32'sh100, 0, 32'sh0005_0000, 32'sh100, 0, 8'd3, 1, 0));
    queue_segment(mk(32'sh0002_0000, -32'sh100, 0, 32'sh0002_0000, 32'sh100, 0, 8'd7, 1, 0));
    queue_segment(mk(32'sh0001_0000, 0, 0, 32'sh0001_0000, 0, 0, 8'd9, 1, 0));
    queue_segment(mk(32'sh0000_8000, -32'sh100, 0, 32'sh0000_8000, 32'sh100, 0, 8'd1, 0, 1));
    queue_segment(mk(0, 0, 0, 32'sh0004_0000, 0, 0, 8'd255, 1, 0));
    queue_segment(mk(-32'sh0002_0000, 0, 0, -32'sh0001_0000, 0, 0, 8'd0, 1, 1));
    queue_segment(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 8'd200, 1, 0));
    queue_segment(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 8'd201, 1, 0));
    queue_segment(mk(32'sh7FFF_0000, 32'sh0, 0, 32'sh7FFF_FFFF, 32'sh0, 0, 8'd5, 1, 1));
    queue_segment(mk(0, 32'sh0003_0000, 0, 0, 32'sh0003_0000, 0, 8'd4, 1, 1));
    wait_idle();

    // Degenerate direction: everything misses.
    set_ray(0, 0, 0, 0, 0, 32'd10, 32'h7FFF_FFFF);
    queue_segment(mk(0, 0, 0, 32'sh0001_0000, 0, 0, 8'd2, 1, 1));
    wait_idle();

    // Extreme registers: maximum radius, negative unit direction, far origin.
    set_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h3_0000, 32'h0, 32'h1_0000, 32'h7FFF_FFFF);
    queue_segment(mk(0, 0, 0, 32'sh0001_0000, 0, 0, 8'd6, 1, 0));
    queue_segment(mk(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                     32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 8'd8, 1, 1));
    wait_idle();
    set_ray(0, 0, 0, 32'h3_0000, 32'h1_0000, 32'h0, 0);
    queue_segment(mk(-32'sh0001_0000, 0, 0, -32'sh0001_0000, 0, 0, 8'd11, 1, 1));
    wait_idle();

    // Random phases with different rays.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: set_ray(0, 0, 0, 32'h1_0000, 0, 0, $urandom_range(100, 40000));
        1: set_ray($urandom_range(0, 65536), $urandom, $urandom, 32'h1_0000,
                   $urandom_range(0, 1) ? 32'h3_FFFF : 32'h1, 32'h2_0000,
                   $urandom_range(0, 65536));
        default: set_ray($urandom_range(0, 200000), 32'hFFFF_0000, 32'h0000_4000,
                         $urandom_range(0, 1) ? 32'h1_0000 : 32'h0_B505,
                         32'h0_0100, 32'h3_FF00, $urandom);
      endcase
      if (ph == 2) hold_off = 1'b1;
      n = 0;
      while (n < 250) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) queue_segment(rand_segment(k == len - 1));
        n += len;
        while (pending_segments.size() > 8) @(posedge clk);
      end
      wait_idle();
    end
    stimulus_done = 1'b1;

    waited = 0;
    while (expected_picks.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_picks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
